### src/idp_pkg.sv
// Shared types and constants for the ISO 8601 duration parser.
`timescale 1ns / 1ps

package idp_pkg;

  localparam int CHAR_W      = 8;
  localparam int TOTAL_W     = 49;
  localparam int OUT_TDATA_W = 56;
  localparam int ACC_W       = 32;
  localparam int WEIGHT_W    = 17;
  localparam int PROD_W      = 48;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h53;

  localparam logic [WEIGHT_W-1:0] W_DAY  = 17'd86400;
  localparam logic [WEIGHT_W-1:0] W_HOUR = 17'd3600;
  localparam logic [WEIGHT_W-1:0] W_MIN  = 17'd60;
  localparam logic [WEIGHT_W-1:0] W_SEC  = 17'd1;

  // Component values saturate here; anything at or above it is an overflow.
  localparam logic [ACC_W-1:0] COMP_SAT = 32'h8000_0000;

  typedef enum logic [3:0] {
    TK_DIGIT,
    TK_MINUS,
    TK_P,
    TK_T,
    TK_D,
    TK_H,
    TK_M,
    TK_S,
    TK_OTHER,
    TK_END
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
  } token_t;

endpackage

### src/idp_front.sv
// Front end: sorts each incoming character into a token class.
`timescale 1ns / 1ps

module idp_front
  import idp_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  input  logic              end_marker,
  output token_t            tok
);

  logic [CHAR_W-1:0] digit_off;

  assign digit_off = char_code - CH_ZERO;

  always_comb begin
    tok.digit = digit_off[3:0];
    if (end_marker) begin
      tok.kind = TK_END;
    end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      tok.kind = TK_DIGIT;
    end else if (char_code == CH_MINUS) begin
      tok.kind = TK_MINUS;
    end else if (char_code == CH_P) begin
      tok.kind = TK_P;
    end else if (char_code == CH_T) begin
      tok.kind = TK_T;
    end else if (char_code == CH_D) begin
      tok.kind = TK_D;
    end else if (char_code == CH_H) begin
      tok.kind = TK_H;
    end else if (char_code == CH_M) begin
      tok.kind = TK_M;
    end else if (char_code == CH_S) begin
      tok.kind = TK_S;
    end else begin
      tok.kind = TK_OTHER;
    end
  end

endmodule

### src/idp_fifo.sv
// Small token queue between the classifier and the parser.
`timescale 1ns / 1ps

module idp_fifo
  import idp_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  token_t push_tok,
  output logic   pop_valid,
  input  logic   pop_ready,
  output token_t pop_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  token_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### src/idp_back.sv
// Back end: parse state machine, component weighting and result register.
`timescale 1ns / 1ps

module idp_back
  import idp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_valid,
  output logic               tok_ready,
  input  token_t             tok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TOTAL_W-1:0] out_total,
  output logic               out_bad
);

  typedef enum logic [3:0] {
    PH_START, PH_SIGN, PH_AFTER_P, PH_DAYS, PH_AFTER_D,
    PH_TIME_H, PH_TIME_M, PH_TIME_S, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               seen_r, seen_nxt;
  logic               err_r, err_nxt;
  logic [TOTAL_W-1:0] sum_r, sum_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic               out_bad_r, out_bad_nxt;

  logic               pop, is_end, out_free;
  logic               take_digit, close_req, close_ok, end_ok, end_bad;
  logic [WEIGHT_W-1:0] weight;
  logic [PROD_W-1:0]  prod_full;
  logic [ACC_W+3:0]   acc_ext, acc_times10;
  logic [ACC_W-1:0]   acc_sat;
  logic [TOTAL_W-1:0] sum_step;

  assign is_end    = (tok.kind == TK_END);
  assign out_free  = !out_valid_r || out_ready;
  assign tok_ready = !is_end || out_free;
  assign pop       = tok_valid && tok_ready;

  // Sign is known before the first component closes, so it is applied here.
  assign sum_step = neg_r ? sum_r - {1'b0, prod_r} : sum_r + {1'b0, prod_r};

  assign acc_ext     = {4'b0, acc_r};
  assign acc_times10 = (acc_ext << 3) + (acc_ext << 1) + {{ACC_W{1'b0}}, tok.digit};
  assign acc_sat     = (acc_times10 > {4'b0, COMP_SAT}) ? COMP_SAT : acc_times10[ACC_W-1:0];

  assign close_ok  = seen_r && !acc_r[ACC_W-1];
  assign prod_full = acc_r[ACC_W-2:0] * weight;

  always_comb begin
    end_ok = (phase_r == PH_AFTER_D) || (phase_r == PH_DONE) ||
             (((phase_r == PH_TIME_H) || (phase_r == PH_TIME_M) ||
               (phase_r == PH_TIME_S)) && !seen_r);
    end_bad = err_r || !end_ok;
  end

  always_comb begin
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    seen_nxt      = seen_r;
    err_nxt       = err_r;
    sum_nxt       = sum_step;
    prod_nxt      = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_total_nxt = out_total_r;
    out_bad_nxt   = out_bad_r;
    take_digit    = 1'b0;
    close_req     = 1'b0;
    weight        = W_SEC;

    if (pop && is_end) begin
      out_valid_nxt = 1'b1;
      out_bad_nxt   = end_bad;
      out_total_nxt = end_bad ? '0 : sum_step;
      phase_nxt     = PH_START;
      neg_nxt       = 1'b0;
      acc_nxt       = '0;
      seen_nxt      = 1'b0;
      err_nxt       = 1'b0;
      sum_nxt       = '0;
    end else if (pop && !err_r) begin
      unique case (phase_r)
        PH_START: begin
          if (tok.kind == TK_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_SIGN;
          end else if (tok.kind == TK_P) begin
            phase_nxt = PH_AFTER_P;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_SIGN: begin
          if (tok.kind == TK_P) phase_nxt = PH_AFTER_P;
          else err_nxt = 1'b1;
        end
        PH_AFTER_P: begin
          if (tok.kind == TK_T) begin
            phase_nxt = PH_TIME_H;
          end else if (tok.kind == TK_DIGIT) begin
            take_digit = 1'b1;
            phase_nxt  = PH_DAYS;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_DAYS: begin
          if (tok.kind == TK_DIGIT) begin
            take_digit = 1'b1;
          end else if (tok.kind == TK_D) begin
            close_req = 1'b1;
            weight    = W_DAY;
            phase_nxt = PH_AFTER_D;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_AFTER_D: begin
          if (tok.kind == TK_T) phase_nxt = PH_TIME_H;
          else err_nxt = 1'b1;
        end
        PH_TIME_H, PH_TIME_M, PH_TIME_S: begin
          if (tok.kind == TK_DIGIT) begin
            take_digit = 1'b1;
          end else if (tok.kind == TK_H && phase_r == PH_TIME_H) begin
            close_req = 1'b1;
            weight    = W_HOUR;
            phase_nxt = PH_TIME_M;
          end else if (tok.kind == TK_M && phase_r != PH_TIME_S) begin
            close_req = 1'b1;
            weight    = W_MIN;
            phase_nxt = PH_TIME_S;
          end else if (tok.kind == TK_S) begin
            close_req = 1'b1;
            weight    = W_SEC;
            phase_nxt = PH_DONE;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase

      if (take_digit) begin
        acc_nxt  = acc_sat;
        seen_nxt = 1'b1;
      end
      if (close_req) begin
        if (close_ok) begin
          prod_nxt = prod_full;
          acc_nxt  = '0;
          seen_nxt = 1'b0;
        end else begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      err_r       <= 1'b0;
      sum_r       <= '0;
      prod_r      <= '0;
      out_valid_r <= 1'b0;
      out_total_r <= '0;
      out_bad_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      seen_r      <= seen_nxt;
      err_r       <= err_nxt;
      sum_r       <= sum_nxt;
      prod_r      <= prod_nxt;
      out_valid_r <= out_valid_nxt;
      out_total_r <= out_total_nxt;
      out_bad_r   <= out_bad_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_total = out_total_r;
  assign out_bad   = out_bad_r;

endmodule

### src/iso8601_duration_parser.sv
// Top level of the streaming ISO 8601 duration parser.
`timescale 1ns / 1ps

// Channel | Direction | Payload
// in_     | request   | tdata[7:0] char_code, tlast end_marker
// out_    | result    | tdata[48:0] total_seconds (signed), tuser malformed
//
// One character request is taken per clock cycle while the queue is not full; the
// limit is the single token the parser consumes each cycle from the queue.
// After its end request is accepted, a result passes through the queue and then
// the parser's result register before it appears.
// rst_n is synchronous and active low; it empties the queue, returns the parser to
// the start of a string and drops out_tvalid.
// A stalled result holds only the parser on end requests; characters keep flowing
// into the queue, and in_tready falls only once the queue is full.

module iso8601_duration_parser
  import idp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [CHAR_W-1:0]      in_tdata,   // [7:0] char_code
  input  logic                   in_tlast,   // end_marker
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [48:0] total_seconds, [55:49] zero
  output logic                   out_tuser   // malformed
);

  token_t             front_tok, queue_tok;
  logic               queue_valid, queue_ready;
  logic [TOTAL_W-1:0] total;

  // Character classification happens before the queue so the parser sees
  // only a compact token per request.
  idp_front u_front (
    .char_code  (in_tdata),
    .end_marker (in_tlast),
    .tok        (front_tok)
  );

  // The queue lets requests keep arriving while the parser waits on a stalled result.
  idp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_tok   (front_tok),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_tok    (queue_tok)
  );

  // The parser weights each closed component by a constant, registers the
  // product and folds it into the running sum in the following cycle.
  idp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (queue_valid),
    .tok_ready (queue_ready),
    .tok       (queue_tok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_total (total),
    .out_bad   (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_W - TOTAL_W){1'b0}}, total};

endmodule

### src/idp_checker.sv
// Port-level checks for the duration parser, bound to the top level.
`timescale 1ns / 1ps

module idp_checker
  import idp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  logic [7:0] pending_r;
  logic       end_acc, res_acc;

  assign end_acc = in_tvalid && in_tready && in_tlast;
  assign res_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (end_acc && !res_acc) begin
      pending_r <= pending_r + 1'b1;
    end else if (res_acc && !end_acc) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[TOTAL_W-1:0] == '0)
    else $error("malformed result carries a non-zero total");

  a_result_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_acc |-> pending_r != 8'd0)
    else $error("result delivered without an earlier end request");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or vanished");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind iso8601_duration_parser idp_checker u_idp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/iso8601_duration_checker.sv
// Checker for the ISO 8601 duration parser: predicts each result and compares it.
`timescale 1ns / 1ps

module iso8601_duration_checker
  import idp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [CHAR_W-1:0]      in_tdata,   // [7:0] char_code
  input  logic                   in_tlast,   // end_marker
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [48:0] total_seconds, [55:49] zero
  input  logic                   out_tuser,  // malformed
  output int                     fail_count,
  output int                     outstanding
);

  typedef enum logic [3:0] {
    SEEK_SIGN_OR_P,
    SEEK_P,
    AFTER_P,
    IN_DAYS,
    AFTER_DAYS,
    IN_HOURS,
    IN_MINUTES,
    IN_SECONDS,
    SECONDS_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] seconds;
    logic               malformed;
  } duration_t;

  parse_phase_t         phase;
  logic                 negative;
  logic [ACC_W-1:0]     component;
  logic                 have_digit;
  logic [PROD_W-1:0]    seconds_total;
  logic                 broken;
  duration_t            durations_due[$];

  function automatic void restart_string();
    phase         = SEEK_SIGN_OR_P;
    negative      = 1'b0;
    component     = '0;
    have_digit    = 1'b0;
    seconds_total = '0;
    broken        = 1'b0;
  endfunction

  // Digits beyond the largest legal value pin the component just above it.
  function automatic void take_digit(input logic [3:0] d);
    logic [63:0] grown;
    grown = {32'b0, component} * 64'd10 + {60'b0, d};
    if (grown > {32'b0, COMP_SAT})
      grown = {32'b0, COMP_SAT};
    component  = grown[ACC_W-1:0];
    have_digit = 1'b1;
  endfunction

  function automatic logic close_unit(input logic [WEIGHT_W-1:0] weight);
    logic [63:0] product;
    if (!have_digit || component >= COMP_SAT)
      return 1'b0;
    product       = {32'b0, component} * {47'b0, weight};
    seconds_total = seconds_total + product[PROD_W-1:0];
    component     = '0;
    have_digit    = 1'b0;
    return 1'b1;
  endfunction

  function automatic void absorb_char(input logic [CHAR_W-1:0] c);
    logic is_digit;
    logic ok;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    ok       = 1'b1;
    case (phase)
      SEEK_SIGN_OR_P: begin
        if (c == CH_MINUS) begin
          negative = 1'b1;
          phase    = SEEK_P;
        end else if (c == CH_P) begin
          phase = AFTER_P;
        end else begin
          ok = 1'b0;
        end
      end
      SEEK_P: begin
        if (c == CH_P) phase = AFTER_P;
        else ok = 1'b0;
      end
      AFTER_P: begin
        if (c == CH_T) begin
          phase = IN_HOURS;
        end else if (is_digit) begin
          take_digit(c[3:0]);
          phase = IN_DAYS;
        end else begin
          ok = 1'b0;
        end
      end
      IN_DAYS: begin
        if (is_digit) begin
          take_digit(c[3:0]);
        end else if (c == CH_D) begin
          ok    = close_unit(W_DAY);
          phase = AFTER_DAYS;
        end else begin
          ok = 1'b0;
        end
      end
      AFTER_DAYS: begin
        if (c == CH_T) phase = IN_HOURS;
        else ok = 1'b0;
      end
      IN_HOURS, IN_MINUTES, IN_SECONDS: begin
        if (is_digit) begin
          take_digit(c[3:0]);
        end else if (c == CH_H && phase == IN_HOURS) begin
          ok    = close_unit(W_HOUR);
          phase = IN_MINUTES;
        end else if (c == CH_M && phase != IN_SECONDS) begin
          ok    = close_unit(W_MIN);
          phase = IN_SECONDS;
        end else if (c == CH_S) begin
          ok    = close_unit(W_SEC);
          phase = SECONDS_DONE;
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase
    if (!ok)
      broken = 1'b1;
  endfunction

  function automatic duration_t close_string();
    duration_t d;
    logic      bad;
    bad = broken;
    if (!bad) begin
      case (phase)
        AFTER_DAYS, SECONDS_DONE:         bad = 1'b0;
        IN_HOURS, IN_MINUTES, IN_SECONDS: bad = have_digit;
        default:                          bad = 1'b1;
      endcase
    end
    d.malformed = bad;
    d.seconds   = '0;
    if (!bad) begin
      d.seconds = {1'b0, seconds_total};
      if (negative)
        d.seconds = ~d.seconds + 1'b1;
    end
    restart_string();
    return d;
  endfunction

  always @(posedge clk) begin
    duration_t want;
    if (!rst_n) begin
      restart_string();
      durations_due.delete();
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (durations_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual total_seconds=%0d malformed=%0b",
                   $time, $signed(out_tdata[TOTAL_W-1:0]), out_tuser);
          fail_count++;
        end else begin
          want = durations_due.pop_front();
          if (out_tdata[TOTAL_W-1:0] !== want.seconds) begin
            $display("%0t: total_seconds mismatch, expected %0d, actual %0d", $time,
                     $signed(want.seconds), $signed(out_tdata[TOTAL_W-1:0]));
            fail_count++;
          end
          if (out_tuser !== want.malformed) begin
            $display("%0t: malformed mismatch, expected %0b, actual %0b", $time,
                     want.malformed, out_tuser);
            fail_count++;
          end
          if (out_tdata[OUT_TDATA_W-1:TOTAL_W] !== '0) begin
            $display("%0t: tdata padding mismatch, expected 0, actual %0h", $time,
                     out_tdata[OUT_TDATA_W-1:TOTAL_W]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tlast)
          durations_due.insert(durations_due.size(), close_string());
        else if (!broken)
          absorb_char(in_tdata);
      end
      outstanding <= durations_due.size();
    end
  end

endmodule

### sim/tb_iso8601_duration_parser.sv
// Testbench top for the ISO 8601 duration parser: stimulus, reset and verdict.
`timescale 1ns / 1ps

module tb_iso8601_duration_parser;
  import idp_pkg::*;

  typedef logic [CHAR_W-1:0] char_t;

  // Items to send over the whole run; the random loop stops once this many have gone.
  localparam int RANDOM_ITEMS = 1300;
  // The longest quiet stretch of a correct run is the receiver's deliberate
  // hold-off, during which the input queue fills and nothing moves at all.
  localparam int HOLD_CYCLES  = 300;
  // Cycles with no request or result accepted before the run is abandoned.
  // Several times the hold-off plus the worst gaps on both sides.
  localparam int IDLE_LIMIT   = 5000;
  // An end request passes through the queue and the result register, so a
  // short tail is ample to catch any result that should not be there.
  localparam int TAIL_CYCLES  = 20;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [CHAR_W-1:0]      in_tdata;   // [7:0] char_code
  logic                   in_tlast;   // end_marker
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [48:0] total_seconds, [55:49] zero
  logic                   out_tuser;  // malformed

  int    fail_count;
  int    outstanding;
  int    sent_items;
  int    strings_sent;
  int    idle_cycles;
  logic  sender_burst;
  logic  hold_req;
  logic  drain_fast;
  char_t text[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  iso8601_duration_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  iso8601_duration_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Appends one character to the end of text.
  task automatic add_char(input char_t c);
    text.insert(text.size(), c);
  endtask

  // Offers one request and returns at the rising edge at which it is taken.
  // Ready is looked at on the falling edge, when everything has settled, so
  // the handshake never depends on the order of events at the rising edge.
  // With no gap the valid stays high and only the payload changes.
  task automatic send_req(input char_t ch, input logic last);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Sends the characters held in text, then the end request that closes the
  // string. The end request's character bits are random: the block must ignore them.
  task automatic send_queued();
    foreach (text[i]) send_req(text[i], 1'b0);
    send_req(char_t'($urandom_range(0, 255)), 1'b1);
    sent_items += text.size() + 1;
  endtask

  task automatic send_text(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_queued();
  endtask

  // Stops offering and waits until every result predicted so far has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Mostly small counts; some sit right at the overflow boundary, and some are
  // far beyond it so that the saturation of the digit run is exercised.
  function automatic longint unsigned pick_component();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 64'($urandom_range(0, 99));
      6:                return 64'($urandom_range(0, 99999));
      7:                return 64'd2147483644 + 64'($urandom_range(0, 7));
      8:                return 64'($urandom);
      default:          return {$urandom, $urandom} % 64'd1000000000000;
    endcase
  endfunction

  function automatic int lead_zeros();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic append_num(input longint unsigned value, input int zeros);
    char_t             digits[$];
    char_t             d;
    longint unsigned   rest;
    rest = value;
    do begin
      d    = char_t'(rest % 10);
      digits.push_front(CH_ZERO + d);
      rest = rest / 10;
    end while (rest != 0);
    repeat (zeros) add_char(CH_ZERO);
    foreach (digits[i]) add_char(digits[i]);
  endtask

  // Builds a well-formed duration with random components into text.
  task automatic build_duration();
    logic days;
    logic hrs;
    logic mins;
    logic secs;
    logic tee;
    text.delete();
    if ($urandom_range(0, 3) == 0) add_char(CH_MINUS);
    add_char(CH_P);
    days = 1'($urandom_range(0, 1));
    hrs  = 1'($urandom_range(0, 1));
    mins = 1'($urandom_range(0, 1));
    secs = 1'($urandom_range(0, 1));
    // An empty time part is legal, so a bare T turns up now and then.
    tee  = hrs | mins | secs | ($urandom_range(0, 3) == 0);
    if (!days && !tee) days = 1'b1;
    if (days) begin
      append_num(pick_component(), lead_zeros());
      add_char(CH_D);
    end
    if (tee) add_char(CH_T);
    if (hrs) begin
      append_num(pick_component(), lead_zeros());
      add_char(CH_H);
    end
    if (mins) begin
      append_num(pick_component(), lead_zeros());
      add_char(CH_M);
    end
    if (secs) begin
      append_num(pick_component(), lead_zeros());
      add_char(CH_S);
    end
  endtask

  // Half the time a glyph from a list, mostly parser characters, else any byte.
  function automatic char_t random_glyph();
    string glyphs;
    glyphs = "-PTDHMS0123456789X ";
    if ($urandom_range(0, 1) == 1)
      return glyphs[$urandom_range(0, glyphs.len() - 1)];
    return char_t'($urandom_range(0, 255));
  endfunction

  // Breaks the string in text in one of several ways, or replaces it by noise.
  task automatic corrupt_text();
    int pos;
    int len;
    case ($urandom_range(0, 5))
      0: if (text.size() > 0) begin
        pos       = $urandom_range(0, text.size() - 1);
        text[pos] = random_glyph();
      end
      1: begin
        pos = $urandom_range(0, text.size());
        text.insert(pos, random_glyph());
      end
      2: if (text.size() > 0) begin
        pos = $urandom_range(0, text.size() - 1);
        text.delete(pos);
      end
      3: begin
        len = $urandom_range(0, text.size());
        while (text.size() > len) void'(text.pop_back());
      end
      4: add_char(random_glyph());
      default: begin
        text.delete();
        len = $urandom_range(0, 6);
        repeat (len) add_char(random_glyph());
      end
    endcase
  endtask

  // Result side. Before each result it stalls for a random number of cycles,
  // except during fast stretches. When the main process asks for it, it holds
  // ready low for a long stretch so that the block backs up and stalls its input.
  initial begin
    int stall;
    out_tready = 1'b0;
    drain_fast = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) drain_fast = ~drain_fast;
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = drain_fast ? 0 : $urandom_range(0, 7);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    hold_req     = 1'b0;
    sender_burst = 1'b0;
    sent_items   = 0;
    strings_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: special cases first, then the largest legal components,
    // with and without a sign, the first overflow, a larger one, two bad starts.
    send_text("");
    send_text("P");
    send_text("-P");
    send_text("PT");
    send_text("P1DT");
    send_text("PTH");
    send_text("PDT1H");
    send_text("PT5");
    send_text("P5");
    send_text("PT1S1M");
    send_text("PT1H1H");
    send_text("PT1M1H");
    send_text("PT0007S");
    send_text("PX1D");
    send_text("PT1SX");
    send_text("-PT0S");
    send_text("P1D");
    send_text("-P3DT4H5M6S");
    send_text("P2147483647DT2147483647H2147483647M2147483647S");
    send_text("-P2147483647DT2147483647H2147483647M2147483647S");
    send_text("PT2147483648S");
    send_text("PT99999999999S");
    send_text("--P1D");
    send_text("1PD");
    wait_drained();

    // Random part: mostly well-formed strings with random components, the
    // rest broken in various ways or plain noise. Early on the receiver is
    // asked to hold off while a burst of strings keeps coming; later the
    // sender pauses until every result is back.
    while (sent_items < RANDOM_ITEMS) begin
      strings_sent++;
      if (strings_sent == 40) hold_req = 1'b1;
      if (strings_sent == 150) wait_drained();
      sender_burst = (strings_sent >= 40 && strings_sent < 55) || ($urandom_range(0, 4) == 0);
      build_duration();
      if ($urandom_range(0, 3) == 0) corrupt_text();
      send_queued();
    end

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
